### rtl/core/cbp_pkg.sv
// Shared types and constants for the clipped blit pixel converter.
// Used by every module under rtl/core; depends on nothing else.
`default_nettype none

package cbp_pkg;

	localparam int CFG_DATA_W = 11;
	localparam int CFG_IDX_W  = 3;

	localparam logic [CFG_IDX_W-1:0] REG_DEST_X     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEST_Y     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_X      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_Y      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PART_W     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PART_H     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_STRIDE = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_FORMAT = 3'd7;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_PIXEL = 1'b1;

	localparam logic KIND_START = 1'b0;
	localparam logic KIND_PIXEL = 1'b1;

	localparam logic FMT_RGB565_SWAP = 1'b0;
	localparam logic FMT_RGB332      = 1'b1;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic signed [10:0] dest_x;
		logic signed [10:0] dest_y;
		logic [9:0]         src_x;
		logic [9:0]         src_y;
		logic [10:0]        part_w;
		logic [10:0]        part_h;
		logic [10:0]        src_stride;
		logic               out_format;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		dest_x:     11'sd0,
		dest_y:     11'sd0,
		src_x:      10'd0,
		src_y:      10'd0,
		part_w:     11'd0,
		part_h:     11'd0,
		src_stride: 11'd1,
		out_format: FMT_RGB565_SWAP
	};

	typedef enum logic {
		OP_START = 1'b0,
		OP_PIXEL = 1'b1
	} op_kind_t;

	typedef struct packed {
		op_kind_t    op;
		logic        empty;
		logic        row_end;
		logic        last;
		logic [10:0] c0;
		logic [20:0] src_mul;
		logic [16:0] dest_mul;
		logic [15:0] pixel;
	} op_t;

	function automatic logic [15:0] convert_pixel(input logic [15:0] p, input logic fmt);
		logic [15:0] res;
		if (fmt == FMT_RGB332) begin
			res = {8'h00, p[15:13], p[10:8], p[4:3]};
		end else begin
			res = {p[7:0], p[15:8]};
		end
		return res;
	endfunction

endpackage

`default_nettype wire

### rtl/core/cbp_front.sv
// Front part: accepts commands, clips the part at start, tracks the visible
// window and forms the row products. Depends on cbp_pkg; feeds cbp_queue.
`default_nettype none

module cbp_front #(
	parameter int SCREEN_WIDTH  = 320,
	parameter int SCREEN_HEIGHT = 240
) (
	input  wire              clk,
	input  wire              arst_n,
	input  cbp_pkg::cfg_t    cfg,
	input  wire              in_valid,
	output logic             in_stall,
	input  wire              command,
	input  wire [15:0]       pixel,
	input  wire              q_full,
	output logic             q_push,
	output cbp_pkg::op_t     q_data
);

	localparam logic signed [12:0] SW13 = 13'(SCREEN_WIDTH);
	localparam logic signed [12:0] SH13 = 13'(SCREEN_HEIGHT);
	localparam logic [16:0]        SW17 = 17'(SCREEN_WIDTH);

	logic        active_q;
	logic [10:0] first_col_q;
	logic [10:0] end_col_q;
	logic [10:0] end_row_q;
	logic [10:0] cur_col_q;
	logic [10:0] cur_row_q;

	logic               accept;
	logic signed [12:0] dx, dy, w, h;
	logic signed [12:0] c0, c1, r0, r1;
	logic               empty;
	logic [11:0]        col_inc, row_inc;
	logic               row_end, last;
	logic [10:0]        row_sel, col_sel;
	logic [11:0]        sy12;
	logic [20:0]        smul;
	logic [16:0]        dy17, dmul;

	assign in_stall = q_full;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		dx = {{2{cfg.dest_x[10]}}, cfg.dest_x};
		dy = {{2{cfg.dest_y[10]}}, cfg.dest_y};
		w  = {2'b00, cfg.part_w};
		h  = {2'b00, cfg.part_h};
		c0 = (dx < 0) ? -dx : 13'sd0;
		c1 = (dx + w > SW13) ? SW13 - dx : w;
		r0 = (dy < 0) ? -dy : 13'sd0;
		r1 = (dy + h > SH13) ? SH13 - dy : h;
		empty = (c0 >= c1) || (r0 >= r1);

		col_inc = {1'b0, cur_col_q} + 12'd1;
		row_inc = {1'b0, cur_row_q} + 12'd1;
		row_end = col_inc >= {1'b0, end_col_q};
		last    = row_end && (row_inc >= {1'b0, end_row_q});

		row_sel = (command == cbp_pkg::CMD_START) ? r0[10:0] : row_inc[10:0];
		col_sel = (command == cbp_pkg::CMD_START) ? c0[10:0] : first_col_q;
		sy12    = {2'b00, cfg.src_y} + {1'b0, row_sel};
		smul    = 21'(sy12) * 21'(cfg.src_stride);
		dy17    = {{6{cfg.dest_y[10]}}, cfg.dest_y} + {6'b0, row_sel};
		dmul    = dy17 * SW17;
	end

	always_comb begin
		q_data.op       = (command == cbp_pkg::CMD_START) ? cbp_pkg::OP_START
			: cbp_pkg::OP_PIXEL;
		q_data.empty    = empty;
		q_data.row_end  = row_end;
		q_data.last     = last;
		q_data.c0       = col_sel;
		q_data.src_mul  = smul;
		q_data.dest_mul = dmul;
		q_data.pixel    = pixel;
		q_push = accept && ((command == cbp_pkg::CMD_START) || active_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			first_col_q <= '0;
			end_col_q   <= '0;
			end_row_q   <= '0;
			cur_col_q   <= '0;
			cur_row_q   <= '0;
		end else if (accept) begin
			if (command == cbp_pkg::CMD_START) begin
				active_q    <= !empty;
				first_col_q <= c0[10:0];
				cur_col_q   <= c0[10:0];
				end_col_q   <= c1[10:0];
				cur_row_q   <= r0[10:0];
				end_row_q   <= r1[10:0];
			end else if (active_q) begin
				if (row_end) begin
					cur_col_q <= first_col_q;
					cur_row_q <= row_inc[10:0];
					if (last) begin
						active_q <= 1'b0;
					end
				end else begin
					cur_col_q <= col_inc[10:0];
				end
			end
		end
	end

endmodule

`default_nettype wire

### rtl/core/cbp_queue.sv
// Short operation queue between the front and back parts.
// Depends on cbp_pkg for the operation type and depth.
`default_nettype none

module cbp_queue (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           push,
	input  cbp_pkg::op_t  push_data,
	input  wire           pop,
	output logic          head_valid,
	output cbp_pkg::op_t  head_data,
	output logic          full
);

	cbp_pkg::op_t                   entry_q [cbp_pkg::QDEPTH];
	logic [cbp_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [cbp_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [cbp_pkg::QCNT_W-1:0]     count_q;
	logic                           do_push, do_pop;

	assign full       = count_q == cbp_pkg::QCNT_W'(cbp_pkg::QDEPTH);
	assign head_valid = count_q != '0;
	assign head_data  = entry_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!do_push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/core/cbp_back.sv
// Back part: computes source and frame-buffer addresses, converts pixels
// and holds the output register. Depends on cbp_pkg.
`default_nettype none

module cbp_back (
	input  wire              clk,
	input  wire              arst_n,
	input  cbp_pkg::cfg_t    cfg,
	input  wire              q_valid,
	input  cbp_pkg::op_t     q_data,
	output logic             q_pop,
	output logic             out_valid,
	input  wire              out_stall,
	output logic             kind,
	output logic             nothing_visible,
	output logic [21:0]      src_offset,
	output logic [16:0]      dest_index,
	output logic [15:0]      dest_data,
	output logic             last
);

	logic [21:0] next_src_q;
	logic [16:0] next_dest_q;

	logic        out_valid_q, kind_q, nv_q, last_q;
	logic [21:0] src_q;
	logic [16:0] dest_q;
	logic [15:0] data_q;

	logic        can_adv;
	logic [20:0] row_sum;
	logic [21:0] row_src;
	logic [16:0] row_dest;

	assign can_adv = !out_valid_q || !out_stall;
	assign q_pop   = q_valid && can_adv;

	always_comb begin
		row_sum  = q_data.src_mul + {11'b0, cfg.src_x} + {10'b0, q_data.c0};
		row_src  = {row_sum, 1'b0};
		row_dest = q_data.dest_mul + {{6{cfg.dest_x[10]}}, cfg.dest_x} + {6'b0, q_data.c0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (can_adv) begin
			out_valid_q <= q_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			unique case (q_data.op)
				cbp_pkg::OP_START: begin
					kind_q <= cbp_pkg::KIND_START;
					dest_q <= '0;
					data_q <= '0;
					if (q_data.empty) begin
						nv_q   <= 1'b1;
						last_q <= 1'b1;
						src_q  <= '0;
					end else begin
						nv_q        <= 1'b0;
						last_q      <= 1'b0;
						src_q       <= row_src;
						next_src_q  <= row_src;
						next_dest_q <= row_dest;
					end
				end
				cbp_pkg::OP_PIXEL: begin
					kind_q <= cbp_pkg::KIND_PIXEL;
					nv_q   <= 1'b0;
					last_q <= q_data.last;
					dest_q <= next_dest_q;
					data_q <= cbp_pkg::convert_pixel(q_data.pixel, cfg.out_format);
					if (q_data.last) begin
						src_q <= '0;
					end else if (q_data.row_end) begin
						src_q       <= row_src;
						next_src_q  <= row_src;
						next_dest_q <= row_dest;
					end else begin
						src_q       <= next_src_q + 22'd2;
						next_src_q  <= next_src_q + 22'd2;
						next_dest_q <= next_dest_q + 17'd1;
					end
				end
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign kind            = kind_q;
	assign nothing_visible = nv_q;
	assign src_offset      = src_q;
	assign dest_index      = dest_q;
	assign dest_data       = data_q;
	assign last            = last_q;

endmodule

`default_nettype wire

### rtl/core/clipped_blit_pixel_convert.sv
// Clipped 2D blit front end with RGB565 to frame-buffer pixel conversion.
// Each start answer and each pixel result passes through one queue stage,
// then the output register.
// Throughput: one transaction per cycle while the queue is not full; the four-entry
// queue and the output register absorb output stalls before the input stalls.
// Reset (arst_n low, asynchronous): idle, queue empty, output not valid, configuration at its defaults.
`default_nettype none

module clipped_blit_pixel_convert #(
	parameter int SCREEN_WIDTH  = 320,
	parameter int SCREEN_HEIGHT = 240
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             cfg_we,
	input  wire [cbp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire [cbp_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire                             in_valid,
	output logic                            in_stall,
	input  wire                             command,
	input  wire [15:0]                      pixel,
	output logic                            out_valid,
	input  wire                             out_stall,
	output logic                            kind,
	output logic                            nothing_visible,
	output logic [21:0]                     src_offset,
	output logic [16:0]                     dest_index,
	output logic [15:0]                     dest_data,
	output logic                            last
);

	cbp_pkg::cfg_t cfg_q;
	cbp_pkg::op_t  push_data, head_data;
	logic          q_push, q_pop, q_full, q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= cbp_pkg::CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cbp_pkg::REG_DEST_X:     cfg_q.dest_x     <= $signed(cfg_data);
				cbp_pkg::REG_DEST_Y:     cfg_q.dest_y     <= $signed(cfg_data);
				cbp_pkg::REG_SRC_X:      cfg_q.src_x      <= cfg_data[9:0];
				cbp_pkg::REG_SRC_Y:      cfg_q.src_y      <= cfg_data[9:0];
				cbp_pkg::REG_PART_W:     cfg_q.part_w     <= cfg_data;
				cbp_pkg::REG_PART_H:     cfg_q.part_h     <= cfg_data;
				cbp_pkg::REG_SRC_STRIDE: cfg_q.src_stride <= cfg_data;
				cbp_pkg::REG_OUT_FORMAT: cfg_q.out_format <= cfg_data[0];
			endcase
		end
	end

	cbp_front #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.command  (command),
		.pixel    (pixel),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_data   (push_data)
	);

	cbp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_data  (push_data),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_data  (head_data),
		.full       (q_full)
	);

	cbp_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.q_valid         (q_valid),
		.q_data          (head_data),
		.q_pop           (q_pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.kind            (kind),
		.nothing_visible (nothing_visible),
		.src_offset      (src_offset),
		.dest_index      (dest_index),
		.dest_data       (dest_data),
		.last            (last)
	);

endmodule

`default_nettype wire

### rtl/core/cbp_checker.sv
// Port-level checker for clipped_blit_pixel_convert, bound to the top level.
// Depends on cbp_pkg for result kind codes.
`default_nettype none

module cbp_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        out_valid,
	input wire        out_stall,
	input wire        kind,
	input wire        nothing_visible,
	input wire [21:0] src_offset,
	input wire [16:0] dest_index,
	input wire [15:0] dest_data,
	input wire        last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(kind) && $stable(last)
			&& $stable(src_offset) && $stable(dest_index) && $stable(dest_data))
		else $error("Stalled result transaction changed.");

	a_empty_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == cbp_pkg::KIND_START && nothing_visible
			|-> last && src_offset == 22'd0 && dest_index == 17'd0 && dest_data == 16'd0)
		else $error("Empty start answer has wrong fields.");

	a_visible_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == cbp_pkg::KIND_START && !nothing_visible
			|-> !last && dest_index == 17'd0 && dest_data == 16'd0)
		else $error("Visible start answer has wrong fields.");

	a_pixel_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == cbp_pkg::KIND_PIXEL
			|-> !nothing_visible && (!last || src_offset == 22'd0))
		else $error("Pixel transaction has wrong flags or offset.");

endmodule

bind clipped_blit_pixel_convert cbp_checker u_cbp_checker (.*);

`default_nettype wire
